### rtl/core/zpsc_pkg.sv
// Package for the zero point sigma clip block.
// Field widths, register indexes and fixed constants; no dependencies.
package zpsc_pkg;

  localparam int unsigned MagW    = 32;
  localparam int unsigned AirW    = 24;
  localparam int unsigned SigW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned SumW    = 40;
  localparam int unsigned SqW     = 64;
  localparam int unsigned MulW    = 33;

  localparam logic [CfgIdxW-1:0] RegCLambda   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegALambda   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSigFactor = 2'd2;

  localparam logic [SigW-1:0] SigFactorReset = 16'd768;
  localparam logic [31:0]     SigmaFloor     = 32'd7;

  typedef logic signed [MagW-1:0] mag_t;
  typedef logic [AirW-1:0]        air_t;
  typedef logic [SigW-1:0]        sig_t;

endpackage

### rtl/core/zpsc_if.sv
// Valid/ready channel interfaces for records, results and register writes.
// Depends on zpsc_pkg.
interface zpsc_in_if;
  logic                  valid;
  logic                  ready;
  zpsc_pkg::mag_t        mcal_in;
  zpsc_pkg::air_t        airmass;
  zpsc_pkg::mag_t        colour_term;
  logic                  is_empty;
  logic                  fixed_in;
  logic                  last_in;
  modport source (output valid, mcal_in, airmass, colour_term, is_empty, fixed_in, last_in,
                  input ready);
  modport sink (input valid, mcal_in, airmass, colour_term, is_empty, fixed_in, last_in,
                output ready);
endinterface

interface zpsc_out_if;
  logic                  valid;
  logic                  ready;
  zpsc_pkg::mag_t        mcal_out;
  zpsc_pkg::mag_t        residual_out;
  logic                  fixed_out;
  logic                  last_out;
  modport source (output valid, mcal_out, residual_out, fixed_out, last_out, input ready);
  modport sink (input valid, mcal_out, residual_out, fixed_out, last_out, output ready);
endinterface

interface zpsc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [zpsc_pkg::CfgIdxW-1:0]         index;
  logic [zpsc_pkg::CfgDatW-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/zpsc_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module zpsc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/zero_point_sigma_clip_top.sv
// Zero point sigma clip: loads image records, clips residuals, emits one result per image.
// Depends on zpsc_pkg, zpsc_if and zpsc_ram.
// Load: each record passes accept, product, residual, square and accumulate steps in turn.
// Close: mean division, mean square division, variance, square root and threshold (all skipped
// when no record qualifies), then each result is read through the store read port, held while results stall.
// Reset clears counts, sums and control and returns registers to reset values; stores are not cleared.
module zero_point_sigma_clip_top #(
  parameter int unsigned MAX_IMAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  zpsc_in_if.sink     in_i,
  zpsc_out_if.source  out_o,
  zpsc_cfg_if.sink    cfg_i
);
  import zpsc_pkg::*;

  localparam int unsigned AW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_IMAGES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LMUL, S_LRES, S_LSQ, S_LACC, S_FSTART, S_DIVM, S_MEAN,
    S_DIVS, S_MSQ, S_VAR, S_SQRT, S_THR, S_THRW, S_ERD, S_EMIT
  } state_e;

  state_e state_q;

  mag_t        c_lambda_q;
  air_t        a_lambda_q;
  sig_t        sig_factor_q;

  mag_t        mcal_q, colour_q, r_q;
  air_t        air_q;
  logic        qual_q, last_q;

  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]         sumsq_q;
  logic [CW-1:0]          qcnt_q, lcnt_q, k_q;
  logic                   all_q;

  logic [63:0]   quo_q;
  logic [CW-1:0] rem_q;
  logic [5:0]    it_q;
  logic signed [31:0] mean_q;
  logic [63:0]   ex2_q, v_q, res_q, bit_q;
  logic [47:0]   thr_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] mul_q;

  logic              out_valid_q;
  mag_t              out_mcal_q, out_res_q;
  logic              out_fixed_q, out_last_q;

  logic [63:0] ram_wdata, ram_rdata;
  logic        ram_we;

  // residual path
  logic [48:0]        prod_rnd;
  logic [35:0]        rw;
  mag_t               r_sat;
  // divider step
  logic [CW:0]        rem_t;
  logic               div_ge;
  // square root step
  logic [64:0]        trial;
  logic               sq_ge;
  // finish path
  logic [SumW-1:0]    sum_abs;
  logic [40:0]        mean_w;
  logic [31:0]        sd;
  logic [64:0]        sumsq_add;
  // emission path
  mag_t               rk, mk;
  logic signed [33:0] dk;
  logic [33:0]        adk;
  logic [48:0]        adk_sh;
  logic               accept;
  logic signed [32:0] mdiff;
  logic               close_set;
  logic               emit_fire;

  assign rk = ram_rdata[63:32];
  assign mk = ram_rdata[31:0];

  function automatic mag_t sat32(input logic signed [35:0] v);
    mag_t y;
    if (v > 36'sh07FFFFFFF) y = 32'sh7FFFFFFF;
    else if (v < -36'sh080000000) y = 32'sh80000000;
    else y = v[31:0];
    return y;
  endfunction

  zpsc_ram #(.Width(64), .Depth(MAX_IMAGES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lcnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_LMUL: begin
        mul_a = $signed({9'd0, a_lambda_q});
        mul_b = $signed({9'd0, air_q});
      end
      S_LSQ: begin
        mul_a = {r_q[31], r_q};
        mul_b = {r_q[31], r_q};
      end
      S_MSQ: begin
        mul_a = {mean_q[31], mean_q};
        mul_b = {mean_q[31], mean_q};
      end
      S_THR: begin
        mul_a = $signed({17'd0, sig_factor_q});
        mul_b = $signed({1'b0, sd});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_rnd  = {1'b0, mul_q[47:0]} + 49'h8000;
  assign rw        = {{4{mcal_q[31]}}, mcal_q} + {{4{c_lambda_q[31]}}, c_lambda_q}
                   + {{4{colour_q[31]}}, colour_q} - {3'd0, prod_rnd[48:16]};
  assign r_sat     = sat32($signed(rw));
  assign ram_we    = (state_q == S_LRES);
  assign ram_wdata = {r_sat, mcal_q};

  assign rem_t  = {rem_q, quo_q[63]};
  assign div_ge = rem_t >= {1'b0, qcnt_q};
  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign sq_ge  = {1'b0, v_q} >= trial;

  assign sum_abs   = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;
  assign mean_w    = sum_q[SumW-1] ? -($signed({1'b0, quo_q[39:0]}) + (rem_q != '0))
                                   : $signed({1'b0, quo_q[39:0]});
  assign sd        = (res_q[31:0] < SigmaFloor) ? SigmaFloor : res_q[31:0];
  assign sumsq_add = {1'b0, sumsq_q} + {1'b0, mul_q[63:0]};

  assign dk     = {{2{rk[31]}}, rk} - {{2{mean_q[31]}}, mean_q};
  assign adk    = dk[33] ? -dk : dk;
  assign adk_sh = {7'd0, adk[33:0], 8'd0};
  assign accept = all_q || !(adk_sh > {1'b0, thr_q});
  assign mdiff  = {mk[31], mk} - {rk[31], rk};

  assign close_set = last_q || ({1'b0, lcnt_q} + 1'b1 == (CW + 1)'(MAX_IMAGES));
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  assign in_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.mcal_out     = out_mcal_q;
  assign out_o.residual_out = out_res_q;
  assign out_o.fixed_out    = out_fixed_q;
  assign out_o.last_out     = out_last_q;

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      c_lambda_q   <= '0;
      a_lambda_q   <= '0;
      sig_factor_q <= SigFactorReset;
      sum_q        <= '0;
      sumsq_q      <= '0;
      qcnt_q       <= '0;
      lcnt_q       <= '0;
      k_q          <= '0;
      all_q        <= 1'b0;
      it_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegCLambda:   c_lambda_q   <= cfg_i.data;
          RegALambda:   a_lambda_q   <= cfg_i.data[AirW-1:0];
          RegSigFactor: sig_factor_q <= cfg_i.data[SigW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            mcal_q   <= in_i.mcal_in;
            air_q    <= in_i.airmass;
            colour_q <= in_i.colour_term;
            qual_q   <= !in_i.is_empty && in_i.fixed_in;
            last_q   <= in_i.last_in;
            state_q  <= S_LMUL;
          end
        end
        S_LMUL: state_q <= S_LRES;
        S_LRES: begin
          r_q     <= r_sat;
          state_q <= S_LSQ;
        end
        S_LSQ: state_q <= S_LACC;
        S_LACC: begin
          if (qual_q) begin
            sum_q   <= sum_q + {{(SumW-32){r_q[31]}}, r_q};
            sumsq_q <= sumsq_add[64] ? '1 : sumsq_add[63:0];
            qcnt_q  <= qcnt_q + 1'b1;
          end
          lcnt_q  <= lcnt_q + 1'b1;
          state_q <= close_set ? S_FSTART : S_IDLE;
        end
        S_FSTART: begin
          k_q <= '0;
          if (qcnt_q == '0) begin
            all_q   <= 1'b1;
            state_q <= S_ERD;
          end else begin
            all_q   <= 1'b0;
            quo_q   <= {24'd0, sum_abs};
            rem_q   <= '0;
            it_q    <= 6'd63;
            state_q <= S_DIVM;
          end
        end
        S_DIVM, S_DIVS: begin
          rem_q <= div_ge ? CW'(rem_t - {1'b0, qcnt_q}) : rem_t[CW-1:0];
          quo_q <= {quo_q[62:0], div_ge};
          it_q  <= it_q - 1'b1;
          if (it_q == '0) begin
            state_q <= (state_q == S_DIVM) ? S_MEAN : S_MSQ;
          end
        end
        S_MEAN: begin
          mean_q  <= mean_w[31:0];
          quo_q   <= sumsq_q;
          rem_q   <= '0;
          it_q    <= 6'd63;
          state_q <= S_DIVS;
        end
        S_MSQ: begin
          ex2_q   <= quo_q;
          state_q <= S_VAR;
        end
        S_VAR: begin
          v_q     <= (ex2_q > mul_q[63:0]) ? ex2_q - mul_q[63:0] : '0;
          res_q   <= '0;
          bit_q   <= 64'd1 << 62;
          it_q    <= 6'd31;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            v_q   <= v_q - trial[63:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          it_q  <= it_q - 1'b1;
          if (it_q == '0) begin
            state_q <= S_THR;
          end
        end
        S_THR: state_q <= S_THRW;
        S_THRW: begin
          thr_q   <= mul_q[47:0];
          state_q <= S_ERD;
        end
        S_ERD: state_q <= S_EMIT;
        S_EMIT: begin
          if (emit_fire) begin
            out_valid_q <= 1'b1;
            out_fixed_q <= accept;
            out_last_q  <= (k_q + 1'b1 == lcnt_q);
            if (accept) begin
              out_mcal_q <= sat32({{3{mdiff[32]}}, mdiff});
              out_res_q  <= '0;
            end else begin
              out_mcal_q <= mk;
              out_res_q  <= rk;
            end
            if (k_q + 1'b1 == lcnt_q) begin
              sum_q   <= '0;
              sumsq_q <= '0;
              qcnt_q  <= '0;
              lcnt_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_ERD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_qcnt_le_lcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= lcnt_q) else $error("qualified count exceeds loaded count");

  a_lcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, lcnt_q} <= (CW + 1)'(MAX_IMAGES)) else $error("loaded count beyond store depth");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_LMUL) else $error("accepted record not loaded");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> k_q < lcnt_q) else $error("emission past loaded entries");

endmodule
